FILE: src/gvn_pkg.sv
// Shared types and fixed widths for the grid vertex normal block.
package gvn_pkg;

    localparam int COORD_W   = 16;
    localparam int NORM_W    = 16;
    localparam int VNUM_W    = 11;
    localparam int SAMP_W    = 6;
    localparam int EDGE_W    = 17;
    localparam int ACC_W     = 40;
    localparam int MUL_W     = 31;
    localparam int PROD_W    = 62;
    localparam int MAG_W     = 38;
    localparam int NMAG_W    = 30;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = 46;
    localparam int QUO_W     = 15;
    localparam int FRAC_N    = 14;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 64;

    localparam logic signed [NORM_W-1:0] UNIT_Z = 16'sd16384;
    localparam logic [SAMP_W-1:0] SAMP_RESET = 6'd32;

    // One grid vertex as it arrives, x in the lowest bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    // Edge vector from the center vertex to one neighbor.
    typedef struct packed {
        logic signed [EDGE_W-1:0] z;
        logic signed [EDGE_W-1:0] y;
        logic signed [EDGE_W-1:0] x;
    } t_edge;

    // Destination of a registered product.
    typedef enum logic [1:0] {
        TAG_X  = 2'd0,
        TAG_Y  = 2'd1,
        TAG_Z  = 2'd2,
        TAG_SQ = 2'd3
    } t_tag;

endpackage

FILE: src/gvn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gvn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 67
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/grid_vertex_normal_top.sv
// Grid vertex normal generator: top level with sequencer and shared datapath.
//
// Usage: vertices of a (S+1) by (S+1) grid enter in raster order on the slave
// stream (tdata = pos_x, pos_y, pos_z). When vertex k is taken, the normal of
// vertex k-(S+1) leaves on the master stream; the last vertex of a grid also
// sends the normals of the whole final row (S+1 more words). tlast marks the
// last word caused by one input word, tuser is the degenerate flag.
// The config channel writes grid_samples and restarts the grid counters; it
// is ready only while the sequencer is idle and takes priority over input.
// Work per vertex: a first-row vertex is only stored; a border vertex goes
// straight to the output. An interior vertex needs 6 window reads from the
// one RAM read port, 36 products through the single 31x31 multiplier,
// one-bit normalizing shifts, 3 squares, 31 square-root steps and three
// restoring divisions. Only one vertex is in work at a time; the slave
// tready is high only while the sequencer is idle.
// Reset clears the counters and sets grid_samples to 32; the window RAM is
// not cleared. When the receiver stalls, the result word holds in the
// output register and no new vertex is taken until all its words are gone.
module grid_vertex_normal_top #(
    parameter int MAX_SAMPLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: pos_x [15:0], pos_y [31:16], pos_z [47:32].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,
    // Master stream: normal_x [15:0], normal_y [31:16], normal_z [47:32],
    // vertex_number [58:48], zero fill [63:59].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,
    // Master tuser: degenerate [0].
    output logic        o_m_tuser,
    output logic        o_m_tlast,
    // Configuration write channel: grid_samples.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    localparam int DEPTH = 2 * (MAX_SAMPLES + 1) + 1;
    localparam int PW    = $clog2(DEPTH);
    localparam logic [gvn_pkg::SAMP_W-1:0] MAX_S = gvn_pkg::SAMP_W'(MAX_SAMPLES);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_CROSS, ST_CWAIT, ST_MAGS, ST_SHIFT,
        ST_SQ, ST_SWAIT, ST_SQRT, ST_DINIT, ST_DIV, ST_EMIT
    } t_state;

    t_state r_state;

    logic [gvn_pkg::SAMP_W-1:0] r_cfg, r_row, r_col, r_fj;
    logic [PW-1:0]              r_wp;
    logic                       r_flush;
    logic [2:0]                 r_k, r_rdk, r_p, r_j;
    logic                       r_rdv;
    gvn_pkg::t_vertex           r_cur, r_ctr;
    gvn_pkg::t_edge             r_e [6];
    logic signed [gvn_pkg::PROD_W-1:0] r_prod;
    logic                       r_pv, r_pneg;
    gvn_pkg::t_tag              r_ptag;
    logic signed [gvn_pkg::ACC_W-1:0] r_acc [3];
    logic [gvn_pkg::MAG_W-1:0]  r_m [3];
    logic                       r_neg [3];
    logic [gvn_pkg::PROD_W-1:0] r_v, r_res, r_bit;
    logic [gvn_pkg::REM_W-1:0]  r_rem, r_dv;
    logic [gvn_pkg::QUO_W-1:0]  r_q;
    logic [3:0]                 r_i;
    logic signed [gvn_pkg::NORM_W-1:0] r_nrm [3];
    logic [gvn_pkg::VNUM_W-1:0] r_vnum;
    logic                       r_deg, r_last, r_m_valid;

    logic [gvn_pkg::SAMP_W-1:0] s_eff, cur_r, cur_t, cr;
    logic [gvn_pkg::SAMP_W:0]   w_eff;
    logic [PW-1:0]              n_wp, rd_addr;
    logic [7:0]                 age8;
    logic [PW:0]                addr_sum;
    logic                       in_acc, has_main, on_border, last_row;
    gvn_pkg::t_vertex           rd_vtx;
    logic [gvn_pkg::IN_DATA_W-1:0] rd_data;
    logic signed [gvn_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [gvn_pkg::PROD_W-1:0] mul_p;
    logic                       mul_neg;
    gvn_pkg::t_tag              mul_tag;
    logic                       m_hi, m_lo;
    logic [gvn_pkg::PROD_W-1:0] sq_try;
    logic [gvn_pkg::QUO_W-1:0]  q_next;
    logic [gvn_pkg::NORM_W-1:0] q_ext;
    logic signed [gvn_pkg::ACC_W-1:0] abs_acc [3];

    function automatic gvn_pkg::t_edge edge_of(gvn_pkg::t_vertex a, gvn_pkg::t_vertex b);
        gvn_pkg::t_edge e;
        e.x = gvn_pkg::EDGE_W'(a.x) - gvn_pkg::EDGE_W'(b.x);
        e.y = gvn_pkg::EDGE_W'(a.y) - gvn_pkg::EDGE_W'(b.y);
        e.z = gvn_pkg::EDGE_W'(a.z) - gvn_pkg::EDGE_W'(b.z);
        return e;
    endfunction

    // Effective grid size and clamped grid position of the arriving vertex.
    always_comb begin
        if (r_cfg == '0) begin
            s_eff = gvn_pkg::SAMP_W'(1);
        end else if (r_cfg > MAX_S) begin
            s_eff = MAX_S;
        end else begin
            s_eff = r_cfg;
        end
        w_eff     = {1'b0, s_eff} + 1'b1;
        cur_r     = (r_row > s_eff) ? '0 : r_row;
        cur_t     = (r_col > s_eff) ? '0 : r_col;
        cr        = cur_r - 1'b1;
        has_main  = (cur_r != '0);
        on_border = (cr == '0) || (cur_t == '0) || (cr == s_eff) || (cur_t == s_eff);
        last_row  = (cur_r == s_eff) && (cur_t == s_eff);
        in_acc    = i_s_tvalid && o_s_tready;
        n_wp      = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    end

    // Window address: the entry of a given age behind the newest one.
    always_comb begin
        case (r_k)
            3'd0:    age8 = {1'b0, w_eff};
            3'd1:    age8 = {1'b0, w_eff} - 8'd1;
            3'd2:    age8 = {w_eff, 1'b0} - 8'd1;
            3'd3:    age8 = {w_eff, 1'b0};
            3'd4:    age8 = {1'b0, w_eff} + 8'd1;
            default: age8 = 8'd1;
        endcase
        addr_sum = {1'b0, r_wp} + (PW+1)'(DEPTH) - {1'b0, PW'(age8)};
        if (addr_sum >= (PW+1)'(DEPTH)) begin
            rd_addr = PW'(addr_sum - (PW+1)'(DEPTH));
        end else begin
            rd_addr = PW'(addr_sum);
        end
    end

    gvn_ram #(
        .WIDTH (gvn_pkg::IN_DATA_W),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (n_wp),
        .i_wdata (i_s_tdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_vtx = gvn_pkg::t_vertex'(rd_data);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_tag = gvn_pkg::TAG_SQ;
        if (r_state == ST_CROSS) begin
            case (r_j)
                3'd0: begin
                    mul_a = gvn_pkg::MUL_W'(r_e[0].y); mul_b = gvn_pkg::MUL_W'(r_e[1].z);
                    mul_tag = gvn_pkg::TAG_X;
                end
                3'd1: begin
                    mul_a = gvn_pkg::MUL_W'(r_e[0].z); mul_b = gvn_pkg::MUL_W'(r_e[1].y);
                    mul_tag = gvn_pkg::TAG_X; mul_neg = 1'b1;
                end
                3'd2: begin
                    mul_a = gvn_pkg::MUL_W'(r_e[0].z); mul_b = gvn_pkg::MUL_W'(r_e[1].x);
                    mul_tag = gvn_pkg::TAG_Y;
                end
                3'd3: begin
                    mul_a = gvn_pkg::MUL_W'(r_e[0].x); mul_b = gvn_pkg::MUL_W'(r_e[1].z);
                    mul_tag = gvn_pkg::TAG_Y; mul_neg = 1'b1;
                end
                3'd4: begin
                    mul_a = gvn_pkg::MUL_W'(r_e[0].x); mul_b = gvn_pkg::MUL_W'(r_e[1].y);
                    mul_tag = gvn_pkg::TAG_Z;
                end
                default: begin
                    mul_a = gvn_pkg::MUL_W'(r_e[0].y); mul_b = gvn_pkg::MUL_W'(r_e[1].x);
                    mul_tag = gvn_pkg::TAG_Z; mul_neg = 1'b1;
                end
            endcase
        end else begin
            mul_a = $signed({1'b0, r_m[r_j[1:0]][gvn_pkg::NMAG_W-1:0]});
            mul_b = mul_a;
        end
        mul_p = mul_a * mul_b;
    end

    // Normalizing range tests, square-root trial and quotient bit.
    always_comb begin
        m_hi = 1'b0;
        m_lo = 1'b1;
        for (int c = 0; c < 3; c++) begin
            m_hi = m_hi | (|r_m[c][gvn_pkg::MAG_W-1:gvn_pkg::NMAG_W]);
            m_lo = m_lo & ~(|r_m[c][gvn_pkg::MAG_W-1:gvn_pkg::NMAG_W-1]);
            abs_acc[c] = r_acc[c][gvn_pkg::ACC_W-1] ? -r_acc[c] : r_acc[c];
        end
        sq_try = r_res + r_bit;
        q_next = {r_q[gvn_pkg::QUO_W-2:0], (r_rem >= r_dv)};
        q_ext  = gvn_pkg::NORM_W'(q_next);
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= gvn_pkg::SAMP_RESET;
            r_row     <= '0;
            r_col     <= '0;
            r_wp      <= '0;
            r_flush   <= 1'b0;
            r_m_valid <= 1'b0;
            r_rdv     <= 1'b0;
            r_pv      <= 1'b0;
            r_k       <= '0;
        end else begin
            r_pv  <= 1'b0;
            r_rdv <= 1'b0;

            // Registered product feeds the accumulators (or the square sum) in the following cycle.
            if (r_pv) begin
                case (r_ptag)
                    gvn_pkg::TAG_X: r_acc[0] <= r_pneg ? r_acc[0] - gvn_pkg::ACC_W'(r_prod)
                                                       : r_acc[0] + gvn_pkg::ACC_W'(r_prod);
                    gvn_pkg::TAG_Y: r_acc[1] <= r_pneg ? r_acc[1] - gvn_pkg::ACC_W'(r_prod)
                                                       : r_acc[1] + gvn_pkg::ACC_W'(r_prod);
                    gvn_pkg::TAG_Z: r_acc[2] <= r_pneg ? r_acc[2] - gvn_pkg::ACC_W'(r_prod)
                                                       : r_acc[2] + gvn_pkg::ACC_W'(r_prod);
                    default:        r_v <= r_v + r_prod;
                endcase
            end

            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
                r_row <= '0;
                r_col <= '0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_wp    <= n_wp;
                        r_cur   <= gvn_pkg::t_vertex'(i_s_tdata);
                        r_vnum  <= gvn_pkg::VNUM_W'(cr) * gvn_pkg::VNUM_W'(w_eff)
                                 + gvn_pkg::VNUM_W'(cur_t);
                        r_flush <= last_row;
                        r_fj    <= '0;
                        r_last  <= !last_row;
                        r_deg   <= 1'b0;
                        r_k     <= '0;
                        for (int c = 0; c < 3; c++) begin
                            r_acc[c] <= '0;
                        end
                        if (cur_t == s_eff) begin
                            r_col <= '0;
                            r_row <= (cur_r == s_eff) ? '0 : cur_r + 1'b1;
                        end else begin
                            r_col <= cur_t + 1'b1;
                            r_row <= cur_r;
                        end
                        if (has_main && on_border) begin
                            r_nrm[0]  <= '0;
                            r_nrm[1]  <= '0;
                            r_nrm[2]  <= gvn_pkg::UNIT_Z;
                            r_m_valid <= 1'b1;
                            r_state   <= ST_EMIT;
                        end else if (has_main) begin
                            r_state <= ST_RD;
                        end
                    end
                end

                // Six window reads; the center comes first.
                ST_RD: begin
                    if (r_k < 3'd6) begin
                        r_k   <= r_k + 1'b1;
                        r_rdv <= 1'b1;
                        r_rdk <= r_k;
                    end
                    if (r_rdv) begin
                        if (r_rdk == 3'd0) begin
                            r_ctr  <= rd_vtx;
                            r_e[5] <= edge_of(r_cur, rd_vtx);
                        end else begin
                            r_e[r_rdk - 1'b1] <= edge_of(rd_vtx, r_ctr);
                        end
                        if (r_rdk == 3'd5) begin
                            r_p     <= '0;
                            r_j     <= '0;
                            r_state <= ST_CROSS;
                        end
                    end
                end

                // Six cross products, six multiplies each; edges rotate.
                ST_CROSS: begin
                    r_prod <= mul_p;
                    r_pv   <= 1'b1;
                    r_ptag <= mul_tag;
                    r_pneg <= mul_neg;
                    if (r_j == 3'd5) begin
                        r_j <= '0;
                        r_p <= r_p + 1'b1;
                        for (int c = 0; c < 5; c++) begin
                            r_e[c] <= r_e[c + 1];
                        end
                        r_e[5] <= r_e[0];
                        if (r_p == 3'd5) begin
                            r_state <= ST_CWAIT;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end

                ST_CWAIT: begin
                    r_state <= ST_MAGS;
                end

                ST_MAGS: begin
                    for (int c = 0; c < 3; c++) begin
                        r_m[c]   <= gvn_pkg::MAG_W'(abs_acc[c]);
                        r_neg[c] <= r_acc[c][gvn_pkg::ACC_W-1];
                    end
                    if (r_acc[0] == '0 && r_acc[1] == '0 && r_acc[2] == '0) begin
                        r_nrm[0]  <= '0;
                        r_nrm[1]  <= '0;
                        r_nrm[2]  <= gvn_pkg::UNIT_Z;
                        r_deg     <= 1'b1;
                        r_m_valid <= 1'b1;
                        r_state   <= ST_EMIT;
                    end else begin
                        r_state <= ST_SHIFT;
                    end
                end

                // One-bit common shift until the largest lies in [2^29, 2^30).
                ST_SHIFT: begin
                    if (m_hi) begin
                        for (int c = 0; c < 3; c++) begin
                            r_m[c] <= r_m[c] >> 1;
                        end
                    end else if (m_lo) begin
                        for (int c = 0; c < 3; c++) begin
                            r_m[c] <= r_m[c] << 1;
                        end
                    end else begin
                        r_j     <= '0;
                        r_v     <= '0;
                        r_state <= ST_SQ;
                    end
                end

                ST_SQ: begin
                    r_prod <= mul_p;
                    r_pv   <= 1'b1;
                    r_ptag <= gvn_pkg::TAG_SQ;
                    r_pneg <= 1'b0;
                    if (r_j == 3'd2) begin
                        r_state <= ST_SWAIT;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end

                ST_SWAIT: begin
                    r_res   <= '0;
                    r_bit   <= gvn_pkg::PROD_W'(1) << (2 * (gvn_pkg::ROOT_W - 1));
                    r_state <= ST_SQRT;
                end

                // Digit-by-digit integer square root, one result bit a cycle.
                ST_SQRT: begin
                    if (r_v >= sq_try) begin
                        r_v   <= r_v - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_j     <= '0;
                        r_state <= ST_DINIT;
                    end
                end

                ST_DINIT: begin
                    r_rem <= gvn_pkg::REM_W'({r_m[r_j[1:0]][gvn_pkg::NMAG_W-1:0],
                                              gvn_pkg::FRAC_N'(0)})
                           + gvn_pkg::REM_W'(r_res[gvn_pkg::ROOT_W-1:1]);
                    r_dv  <= gvn_pkg::REM_W'({r_res[gvn_pkg::ROOT_W-1:0],
                                              gvn_pkg::FRAC_N'(0)});
                    r_q   <= '0;
                    r_i   <= 4'(gvn_pkg::FRAC_N);
                    r_state <= ST_DIV;
                end

                // Restoring division, one quotient bit a cycle.
                ST_DIV: begin
                    if (r_rem >= r_dv) begin
                        r_rem <= r_rem - r_dv;
                    end
                    r_dv <= r_dv >> 1;
                    r_q  <= q_next;
                    r_i  <= r_i - 1'b1;
                    if (r_i == '0) begin
                        r_nrm[r_j[1:0]] <= r_neg[r_j[1:0]] ? -$signed(q_ext) : $signed(q_ext);
                        if (r_j == 3'd2) begin
                            r_m_valid <= 1'b1;
                            r_state   <= ST_EMIT;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_DINIT;
                        end
                    end
                end

                // Hold the word until taken; then send the final row if due.
                ST_EMIT: begin
                    if (i_m_tready) begin
                        if (r_flush) begin
                            r_nrm[0] <= '0;
                            r_nrm[1] <= '0;
                            r_nrm[2] <= gvn_pkg::UNIT_Z;
                            r_deg    <= 1'b0;
                            r_vnum   <= gvn_pkg::VNUM_W'(s_eff) * gvn_pkg::VNUM_W'(w_eff)
                                      + gvn_pkg::VNUM_W'(r_fj);
                            r_last   <= (r_fj == s_eff);
                            r_fj     <= r_fj + 1'b1;
                            if (r_fj == s_eff) begin
                                r_flush <= 1'b0;
                            end
                        end else begin
                            r_m_valid <= 1'b0;
                            r_state   <= ST_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A configuration write wins over an input word in the same idle cycle.
    assign o_s_tready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {5'b0, r_vnum, r_nrm[2], r_nrm[1], r_nrm[0]};
    assign o_m_tuser   = r_deg;
    assign o_m_tlast   = r_last;

    // A result word is only presented by the output state.
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_state == ST_EMIT))
        else $error("result valid outside output state");

    // Input is never taken while a result word is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result pending");

    // A degenerate sum always yields the straight-up normal.
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (r_nrm[0] == '0 && r_nrm[1] == '0
                                       && r_nrm[2] == gvn_pkg::UNIT_Z))
        else $error("degenerate word with wrong normal");

    // A taken word that is not the last of its run is followed at once.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("run of result words broken");

endmodule
